>>> hw/rtl/rbht_pkg.sv
// shared types, constants and helpers for the rule based hyperparameter tuner
package rbht_pkg;

  localparam int VAL_W       = 24;
  localparam int ARM_W       = 16;
  localparam int FRAC_W      = 16;
  localparam int FACT_W      = 17;
  localparam int CFG_INDEX_W = 3;
  localparam int CLAMP_W     = VAL_W + 2;

  // the interpolation quotient stays below F_HI - F_LO, so 15 bits, 3 per stage
  localparam int DIV_Q_W      = 15;
  localparam int DIV_STAGES   = 5;
  localparam int PIPE_LATENCY = DIV_STAGES + 10;

  localparam logic [VAL_W-1:0] GAIN_MIN    = 24'd13107;
  localparam logic [VAL_W-1:0] GAIN_MAX    = 24'd196608;
  localparam logic [VAL_W-1:0] PENALTY_MIN = 24'd1311;
  localparam logic [VAL_W-1:0] PENALTY_MAX = 24'd131072;

  localparam int Q16_ONE      = 65536;
  localparam int BLEND_WEIGHT = 22938;
  localparam int BETA         = (BLEND_WEIGHT > Q16_ONE) ? Q16_ONE : BLEND_WEIGHT;
  localparam int RND          = 32768;

  localparam logic [FACT_W-1:0] F_ONE    = 17'd65536;
  localparam logic [FACT_W-1:0] F_LO     = 17'd60293;
  localparam logic [FACT_W-1:0] F_HI     = 17'd79954;
  localparam logic [FACT_W-1:0] F_SIG_UP = 17'd81920;
  localparam logic [FACT_W-1:0] F_SIG_DN = 17'd57672;
  localparam logic [FACT_W-1:0] F_DELAY  = 17'd73400;
  localparam logic [FACT_W-1:0] F_PEN_UP = 17'd78643;
  localparam logic [FACT_W-1:0] F_PEN_DN = 17'd58982;
  localparam logic [FACT_W-1:0] F_SPAN   = F_HI - F_LO;

  localparam logic [VAL_W-1:0] RST_BASE_GAIN    = 24'd65536;
  localparam logic [VAL_W-1:0] RST_BASE_PENALTY = 24'd6554;
  localparam logic [VAL_W-1:0] RST_SIGMA_LOW    = 24'd5243;
  localparam logic [VAL_W-1:0] RST_SIGMA_HIGH   = 24'd16384;
  localparam logic [VAL_W-1:0] RST_DELAY_HIGH   = 24'd20480;
  localparam logic [VAL_W-1:0] RST_SWITCH_HIGH  = 24'd131072;
  localparam logic [VAL_W-1:0] RST_SWITCH_LOW   = 24'd16384;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_GAIN,
    REG_BASE_PENALTY,
    REG_SIGMA_LOW,
    REG_SIGMA_HIGH,
    REG_DELAY_HIGH,
    REG_SWITCH_HIGH,
    REG_SWITCH_LOW,
    REG_CONT_MODE
  } cfg_reg_t;

  typedef struct packed {
    logic [VAL_W-1:0] base_gain;
    logic [VAL_W-1:0] base_penalty;
    logic [VAL_W-1:0] sigma_low;
    logic [VAL_W-1:0] sigma_high;
    logic [VAL_W-1:0] delay_high;
    logic [VAL_W-1:0] switch_high;
    logic [VAL_W-1:0] switch_low;
    logic             continuous_mode;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] sigma;
    logic [VAL_W-1:0] delay;
    logic [VAL_W-1:0] srate;
    logic [VAL_W-1:0] cur_gain;
    logic [VAL_W-1:0] cur_pen;
  } meas_t;

  typedef struct packed {
    logic [VAL_W-1:0] tgain;
    logic [VAL_W-1:0] tpen;
    logic [VAL_W-1:0] cur_gain;
    logic [VAL_W-1:0] cur_pen;
  } target_t;

  // max with lo first, then min with hi, so hi wins when lo > hi
  function automatic logic [VAL_W-1:0] clamp_val(input logic [CLAMP_W-1:0] x,
                                                 input logic [VAL_W-1:0]   lo,
                                                 input logic [VAL_W-1:0]   hi);
    logic [CLAMP_W-1:0] y;
    y = (x < CLAMP_W'(lo)) ? CLAMP_W'(lo) : x;
    return (y > CLAMP_W'(hi)) ? hi : y[VAL_W-1:0];
  endfunction

endpackage

>>> hw/rtl/rule_based_hyperparameter_tuner.sv
// top level of the rule based hyperparameter tuner
//
// Usage: raise start for one cycle with mean_sigma, mean_delay, switch_rate,
// arm_count, current_gain and current_penalty; the item is taken at the clock
// edge where start is high and busy is low. busy is high only during reset,
// so a new item can be taken in every cycle.
// An item with arm_count of zero is taken and dropped: it gives no result.
// Every other item gives one result: done is high for exactly one cycle with
// new_gain and new_penalty. The receiver cannot stall; results leave in the
// order items came in. Throughput is one item per clock. The pipeline has
// 15 register stages: input capture, rule decode, numerator multiply, five
// divider stages of three quotient bits each for the sigma interpolation,
// factor select, three gain factor multiplies, clamp, blend multiply and
// blend sum. The user must write registers on the cfg channel (cfg_valid with
// cfg_ready) only while no item is in flight; the block does not enforce
// this. cfg_index 0..7 follows the register list. A synchronous reset
// empties the pipeline and returns registers to defaults.
module rule_based_hyperparameter_tuner import rbht_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VAL_W-1:0]       mean_sigma,
  input  logic [VAL_W-1:0]       mean_delay,
  input  logic [VAL_W-1:0]       switch_rate,
  input  logic [ARM_W-1:0]       arm_count,
  input  logic [VAL_W-1:0]       current_gain,
  input  logic [VAL_W-1:0]       current_penalty,
  output logic                   done,
  output logic [VAL_W-1:0]       new_gain,
  output logic [VAL_W-1:0]       new_penalty,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]       cfg_data
);

  cfg_t    cfg;
  meas_t   meas;
  logic    in_valid;
  logic    tgt_valid;
  target_t tgt;

  assign busy = rst;

  rbht_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(cfg_valid),
    .wr_ready(cfg_ready),
    .wr_index(cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // input capture; zero arms never enter the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && (arm_count != '0);
    end
  end

  always_ff @(posedge clk) begin
    meas.sigma    <= mean_sigma;
    meas.delay    <= mean_delay;
    meas.srate    <= switch_rate;
    meas.cur_gain <= current_gain;
    meas.cur_pen  <= current_penalty;
  end

  rbht_target u_target (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .meas     (meas),
    .cfg      (cfg),
    .out_valid(tgt_valid),
    .tgt      (tgt)
  );

  rbht_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (tgt_valid),
    .tgt        (tgt),
    .out_valid  (done),
    .new_gain   (new_gain),
    .new_penalty(new_penalty)
  );

endmodule

>>> hw/rtl/rbht_cfg.sv
// configuration register file of the tuner
module rbht_cfg import rbht_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_valid,
  output logic                   wr_ready,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [VAL_W-1:0]       wr_data,
  output cfg_t                   cfg
);

  assign wr_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_gain       <= RST_BASE_GAIN;
      cfg.base_penalty    <= RST_BASE_PENALTY;
      cfg.sigma_low       <= RST_SIGMA_LOW;
      cfg.sigma_high      <= RST_SIGMA_HIGH;
      cfg.delay_high      <= RST_DELAY_HIGH;
      cfg.switch_high     <= RST_SWITCH_HIGH;
      cfg.switch_low      <= RST_SWITCH_LOW;
      cfg.continuous_mode <= 1'b1;
    end else if (wr_valid) begin
      case (cfg_reg_t'(wr_index))
        REG_BASE_GAIN:    cfg.base_gain       <= wr_data;
        REG_BASE_PENALTY: cfg.base_penalty    <= wr_data;
        REG_SIGMA_LOW:    cfg.sigma_low       <= wr_data;
        REG_SIGMA_HIGH:   cfg.sigma_high      <= wr_data;
        REG_DELAY_HIGH:   cfg.delay_high      <= wr_data;
        REG_SWITCH_HIGH:  cfg.switch_high     <= wr_data;
        REG_SWITCH_LOW:   cfg.switch_low      <= wr_data;
        REG_CONT_MODE:    cfg.continuous_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/rbht_div.sv
// pipelined restoring divider, a few quotient bits per stage
module rbht_div import rbht_pkg::*; #(
  parameter int NUM_W  = VAL_W + DIV_Q_W,
  parameter int DEN_W  = VAL_W,
  parameter int Q_W    = DIV_Q_W,
  parameter int STAGES = DIV_STAGES
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  // Q_W is a multiple of STAGES; num / den must fit in Q_W bits
  localparam int STEPS = Q_W / STAGES;
  localparam int REM_W = DEN_W + 1;

  logic [REM_W-1:0] rem_r [STAGES];
  logic [Q_W-1:0]   low_r [STAGES];
  logic [Q_W-1:0]   quo_r [STAGES];
  logic [DEN_W-1:0] den_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [REM_W-1:0] src_rem;
    logic [Q_W-1:0]   src_low;
    logic [Q_W-1:0]   src_quo;
    logic [DEN_W-1:0] src_den;
    logic [REM_W-1:0] rem_next;
    logic [Q_W-1:0]   low_next;
    logic [Q_W-1:0]   quo_next;

    if (s == 0) begin : g_first
      assign src_rem = REM_W'(num >> Q_W);
      assign src_low = num[Q_W-1:0];
      assign src_quo = '0;
      assign src_den = den;
    end else begin : g_rest
      assign src_rem = rem_r[s-1];
      assign src_low = low_r[s-1];
      assign src_quo = quo_r[s-1];
      assign src_den = den_r[s-1];
    end

    always_comb begin
      rem_next = src_rem;
      low_next = src_low;
      quo_next = src_quo;
      for (int i = 0; i < STEPS; i++) begin
        rem_next = {rem_next[REM_W-2:0], low_next[Q_W-1]};
        low_next = {low_next[Q_W-2:0], 1'b0};
        if (rem_next >= {1'b0, src_den}) begin
          rem_next = rem_next - {1'b0, src_den};
          quo_next = {quo_next[Q_W-2:0], 1'b1};
        end else begin
          quo_next = {quo_next[Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_next;
      low_r[s] <= low_next;
      quo_r[s] <= quo_next;
      den_r[s] <= src_den;
    end
  end

  assign quo = quo_r[STAGES-1];

endmodule

>>> hw/rtl/rbht_target.sv
// target gain and penalty: rule decode, sigma interpolation, factor chain, clamp
module rbht_target import rbht_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  meas_t   meas,
  input  cfg_t    cfg,
  output logic    out_valid,
  output target_t tgt
);

  localparam int GX_W   = VAL_W + 1;
  localparam int PROD_W = GX_W + FACT_W;
  localparam int NUM_W  = VAL_W + DIV_Q_W;

  typedef enum logic [2:0] {
    SIG_NONE,
    SIG_LO,
    SIG_HI,
    SIG_INTERP,
    SIG_UP,
    SIG_DN
  } sig_sel_t;

  typedef struct packed {
    sig_sel_t         sel;
    logic             delay_up;
    logic             sw_high;
    logic             sw_low;
    logic [VAL_W-1:0] d;
    logic [VAL_W-1:0] r;
    logic [VAL_W-1:0] cur_gain;
    logic [VAL_W-1:0] cur_pen;
  } dec_t;

  typedef struct packed {
    sig_sel_t         sel;
    logic             delay_up;
    logic             sw_high;
    logic [GX_W-1:0]  pen_scaled;
    logic [VAL_W-1:0] cur_gain;
    logic [VAL_W-1:0] cur_pen;
  } side_t;

  typedef struct packed {
    logic             delay_up;
    logic             sw_high;
    logic [GX_W-1:0]  pen_scaled;
    logic [VAL_W-1:0] cur_gain;
    logic [VAL_W-1:0] cur_pen;
  } carry_t;

  // stage 1: compares and differences
  dec_t dec, dec_next;
  logic v1;

  always_comb begin
    dec_next.sel = SIG_NONE;
    if (cfg.continuous_mode && (cfg.sigma_high > cfg.sigma_low)) begin
      if (meas.sigma <= cfg.sigma_low) begin
        dec_next.sel = SIG_LO;
      end else if (meas.sigma >= cfg.sigma_high) begin
        dec_next.sel = SIG_HI;
      end else begin
        dec_next.sel = SIG_INTERP;
      end
    end else if (meas.sigma > cfg.sigma_high) begin
      dec_next.sel = SIG_UP;
    end else if (meas.sigma < cfg.sigma_low) begin
      dec_next.sel = SIG_DN;
    end
    dec_next.delay_up = meas.delay > cfg.delay_high;
    dec_next.sw_high  = meas.srate > cfg.switch_high;
    dec_next.sw_low   = meas.srate < cfg.switch_low;
    dec_next.d        = meas.sigma - cfg.sigma_low;
    dec_next.r        = cfg.sigma_high - cfg.sigma_low;
    dec_next.cur_gain = meas.cur_gain;
    dec_next.cur_pen  = meas.cur_pen;
  end

  always_ff @(posedge clk) begin
    dec <= dec_next;
  end

  // stage 2: interpolation numerator and the penalty factor
  side_t            side2, side2_next;
  logic [NUM_W-1:0] num, num_next;
  logic [VAL_W-1:0] den;
  logic [FACT_W-1:0] pen_fact;
  logic [PROD_W-1:0] pen_prod;
  logic v2;

  always_comb begin
    if (dec.sw_high) begin
      pen_fact = F_PEN_UP;
    end else if (dec.sw_low) begin
      pen_fact = F_PEN_DN;
    end else begin
      pen_fact = F_ONE;
    end
    pen_prod = PROD_W'(cfg.base_penalty) * PROD_W'(pen_fact) + PROD_W'(RND);
    num_next = NUM_W'(F_SPAN) * NUM_W'(dec.d);
    side2_next.sel        = dec.sel;
    side2_next.delay_up   = dec.delay_up;
    side2_next.sw_high    = dec.sw_high;
    side2_next.pen_scaled = pen_prod[FRAC_W +: GX_W];
    side2_next.cur_gain   = dec.cur_gain;
    side2_next.cur_pen    = dec.cur_pen;
  end

  always_ff @(posedge clk) begin
    side2 <= side2_next;
    num   <= num_next;
    den   <= dec.r;
  end

  // divider stages, with the rest of the item alongside
  logic [DIV_Q_W-1:0] quo;
  side_t side_line [DIV_STAGES];
  logic [DIV_STAGES-1:0] vline;

  rbht_div #(
    .NUM_W (NUM_W),
    .DEN_W (VAL_W),
    .Q_W   (DIV_Q_W),
    .STAGES(DIV_STAGES)
  ) u_div (
    .clk(clk),
    .num(num),
    .den(den),
    .quo(quo)
  );

  always_ff @(posedge clk) begin
    side_line[0] <= side2;
    for (int i = 1; i < DIV_STAGES; i++) begin
      side_line[i] <= side_line[i-1];
    end
  end

  // factor select
  side_t side_last;
  logic [FACT_W-1:0] sig_fact, sig_fact_next;
  carry_t cf;
  logic vf;

  assign side_last = side_line[DIV_STAGES-1];

  always_comb begin
    case (side_last.sel)
      SIG_LO:     sig_fact_next = F_LO;
      SIG_HI:     sig_fact_next = F_HI;
      SIG_INTERP: sig_fact_next = F_LO + FACT_W'(quo);
      SIG_UP:     sig_fact_next = F_SIG_UP;
      SIG_DN:     sig_fact_next = F_SIG_DN;
      default:    sig_fact_next = F_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    sig_fact       <= sig_fact_next;
    cf.delay_up    <= side_last.delay_up;
    cf.sw_high     <= side_last.sw_high;
    cf.pen_scaled  <= side_last.pen_scaled;
    cf.cur_gain    <= side_last.cur_gain;
    cf.cur_pen     <= side_last.cur_pen;
  end

  // gain factor chain: sigma, delay, switch rate; a factor of one leaves the value as is
  logic [PROD_W-1:0] p1, p2, p3;
  carry_t c1, c2, c3;
  logic vg1, vg2, vg3;

  always_ff @(posedge clk) begin
    p1 <= PROD_W'(cfg.base_gain) * PROD_W'(sig_fact) + PROD_W'(RND);
    c1 <= cf;
    p2 <= PROD_W'(p1[FRAC_W +: GX_W]) * PROD_W'(c1.delay_up ? F_DELAY : F_ONE)
          + PROD_W'(RND);
    c2 <= c1;
    p3 <= PROD_W'(p2[FRAC_W +: GX_W]) * PROD_W'(c2.sw_high ? F_LO : F_ONE)
          + PROD_W'(RND);
    c3 <= c2;
  end

  // clamp to range
  always_ff @(posedge clk) begin
    tgt.tgain    <= clamp_val(CLAMP_W'(p3[FRAC_W +: GX_W]), GAIN_MIN, GAIN_MAX);
    tgt.tpen     <= clamp_val(CLAMP_W'(c3.pen_scaled), PENALTY_MIN, PENALTY_MAX);
    tgt.cur_gain <= c3.cur_gain;
    tgt.cur_pen  <= c3.cur_pen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      vline     <= '0;
      vf        <= 1'b0;
      vg1       <= 1'b0;
      vg2       <= 1'b0;
      vg3       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      vline     <= {vline[DIV_STAGES-2:0], v2};
      vf        <= vline[DIV_STAGES-1];
      vg1       <= vf;
      vg2       <= vg1;
      vg3       <= vg2;
      out_valid <= vg3;
    end
  end

endmodule

>>> hw/rtl/rbht_blend.sv
// blend of target toward current values, final clamp and result register
module rbht_blend import rbht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  target_t          tgt,
  output logic             out_valid,
  output logic [VAL_W-1:0] new_gain,
  output logic [VAL_W-1:0] new_penalty
);

  localparam int DIFF_W  = VAL_W + 1;
  localparam int BETA_W  = FACT_W + 1;
  localparam int BPROD_W = DIFF_W + BETA_W;
  localparam int PAD_W   = BPROD_W - VAL_W - FRAC_W;

  localparam logic signed [BETA_W-1:0]  BETA_S = BETA_W'(BETA);
  localparam logic signed [BPROD_W-1:0] RND_S  = BPROD_W'(RND);

  // (1-b)*cur + b*tgt is cur + b*(tgt-cur), one multiplier per lane
  logic signed [DIFF_W-1:0]  diff_g, diff_p;
  logic signed [BPROD_W-1:0] prod_g, prod_p;
  logic [VAL_W-1:0]          cur_g, cur_p;
  logic                      vb;

  assign diff_g = $signed({1'b0, tgt.tgain}) - $signed({1'b0, tgt.cur_gain});
  assign diff_p = $signed({1'b0, tgt.tpen}) - $signed({1'b0, tgt.cur_pen});

  always_ff @(posedge clk) begin
    prod_g <= BPROD_W'(diff_g) * BPROD_W'(BETA_S);
    prod_p <= BPROD_W'(diff_p) * BPROD_W'(BETA_S);
    cur_g  <= tgt.cur_gain;
    cur_p  <= tgt.cur_pen;
  end

  logic signed [BPROD_W-1:0] sum_g, sum_p;

  assign sum_g = prod_g + $signed({{PAD_W{1'b0}}, cur_g, {FRAC_W{1'b0}}}) + RND_S;
  assign sum_p = prod_p + $signed({{PAD_W{1'b0}}, cur_p, {FRAC_W{1'b0}}}) + RND_S;

  always_ff @(posedge clk) begin
    new_gain    <= clamp_val(sum_g[FRAC_W +: CLAMP_W], GAIN_MIN, GAIN_MAX);
    new_penalty <= clamp_val(sum_p[FRAC_W +: CLAMP_W], PENALTY_MIN, PENALTY_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vb        <= in_valid;
      out_valid <= vb;
    end
  end

endmodule

>>> hw/rtl/rbht_checker.sv
// port level checks of the tuner, bound to the top level
module rbht_checker import rbht_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic [ARM_W-1:0] arm_count,
  input logic             done,
  input logic [VAL_W-1:0] new_gain,
  input logic [VAL_W-1:0] new_penalty
);

  logic take;

  // a transfer that must produce a result
  assign take = start && !busy && (arm_count != '0);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |-> ##PIPE_LATENCY done)
    else $error("result missing after fixed latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, PIPE_LATENCY))
    else $error("result without matching input transfer");

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    done |-> (new_gain <= GAIN_MAX) && (new_penalty <= PENALTY_MAX))
    else $error("result above clamp limit");

endmodule

bind rule_based_hyperparameter_tuner rbht_checker u_rbht_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .arm_count  (arm_count),
  .done       (done),
  .new_gain   (new_gain),
  .new_penalty(new_penalty)
);
